### src/a85_pkg.sv
// Shared types, codes and constants for the ASCII85 decoder.
// No dependencies; every other file of the block imports this package.
package a85_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [7:0] CH_ZERO_GROUP = 8'h7A;  // 'z'
  localparam logic [7:0] CH_DIGIT_LOW  = 8'h21;  // '!'
  localparam logic [7:0] CH_DIGIT_HIGH = 8'h75;  // 'u'
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;

  localparam logic [2:0] GROUP_DIGITS  = 3'd5;
  localparam logic [2:0] GROUP_BYTES   = 3'd4;
  localparam logic [19:0] RADIX        = 20'd85;

  typedef enum logic [2:0] {
    KIND_BYTE       = 3'd0,
    KIND_DONE       = 3'd1,
    KIND_Z_IN_GROUP = 3'd2,
    KIND_BAD_CHAR   = 3'd3,
    KIND_INCOMPLETE = 3'd4
  } kind_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      kind;
    logic       last;
  } out_item_t;

  // One queued job: up to four bytes of word, then an optional closing result.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num_bytes;
    logic        has_tail;
    kind_t       tail_kind;
  } job_t;

  // 85^k for padding k missing digits with 'u' (k = 1 to 3; 1 otherwise).
  function automatic logic [19:0] pow85(input logic [2:0] k);
    logic [19:0] p;
    case (k)
      3'd1:    p = 20'd85;
      3'd2:    p = 20'd7225;
      3'd3:    p = 20'd614125;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage

### src/a85_front.sv
// Front end: accepts characters, keeps the base-85 group state and
// builds one job per item that yields results. Uses a85_pkg.
module a85_front
  import a85_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [31:0] val_r, val_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        failed_r, failed_nxt;

  logic        accept;
  logic        is_ws;
  logic [7:0]  c;
  logic [6:0]  digit;
  logic [19:0] mul_k;
  logic [31:0] addend;
  logic [51:0] prod_w;
  logic [31:0] prod;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.char_code;
  assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  assign digit    = 7'(c - CH_DIGIT_LOW);

  // One multiply-add: a digit step, or padding the group with 'u' digits at end.
  always_comb begin
    if (in_data.op == OP_END) begin
      mul_k  = pow85(GROUP_DIGITS - cnt_r);
      addend = 32'(mul_k) - 32'd1;
    end else begin
      mul_k  = RADIX;
      addend = {25'd0, digit};
    end
  end

  assign prod_w = val_r * mul_k;
  assign prod   = prod_w[31:0] + addend;

  always_comb begin
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    failed_nxt = failed_r;
    q_push     = 1'b0;
    q_job      = '0;
    q_job.tail_kind = KIND_DONE;
    if (accept) begin
      if (in_data.op == OP_END) begin
        if (!failed_r) begin
          q_push = 1'b1;
          q_job.word = prod;
          q_job.has_tail = 1'b1;
          if (cnt_r == 3'd1) begin
            q_job.tail_kind = KIND_INCOMPLETE;
          end else if (cnt_r != 3'd0) begin
            q_job.num_bytes = cnt_r - 3'd1;
          end
        end
        val_nxt    = '0;
        cnt_nxt    = '0;
        failed_nxt = 1'b0;
      end else if (!failed_r && !is_ws) begin
        if (c == CH_ZERO_GROUP) begin
          q_push = 1'b1;
          if (cnt_r != 3'd0) begin
            failed_nxt      = 1'b1;
            q_job.has_tail  = 1'b1;
            q_job.tail_kind = KIND_Z_IN_GROUP;
          end else begin
            q_job.num_bytes = GROUP_BYTES;
          end
        end else if (c < CH_DIGIT_LOW || c > CH_DIGIT_HIGH) begin
          q_push          = 1'b1;
          failed_nxt      = 1'b1;
          q_job.has_tail  = 1'b1;
          q_job.tail_kind = KIND_BAD_CHAR;
        end else if (cnt_r == GROUP_DIGITS - 3'd1) begin
          // fifth digit: emit the group and start over
          q_push          = 1'b1;
          q_job.word      = prod;
          q_job.num_bytes = GROUP_BYTES;
          val_nxt         = '0;
          cnt_nxt         = '0;
        end else begin
          val_nxt = prod;
          cnt_nxt = cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r    <= '0;
      cnt_r    <= '0;
      failed_r <= 1'b0;
    end else begin
      val_r    <= val_nxt;
      cnt_r    <= cnt_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

### src/a85_queue.sv
// Two-entry job queue between front and back end.
// Uses job_t and queue constants from a85_pkg.
module a85_queue
  import a85_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### src/a85_back.sv
// Back end: registers the head job's results one per cycle unless stalled.
// Uses job_t, out_item_t and kind codes from a85_pkg.
module a85_back
  import a85_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign total   = head_job.num_bytes + {2'd0, head_job.has_tail};
  assign is_last = ({1'b0, idx_r} + 3'd1 == total);
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign pop     = load && is_last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head_job.word[31:24];
      2'd1:    sel_byte = head_job.word[23:16];
      2'd2:    sel_byte = head_job.word[15:8];
      default: sel_byte = head_job.word[7:0];
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if ({1'b0, idx_r} < head_job.num_bytes) begin
        out_data_nxt.data_byte = sel_byte;
        out_data_nxt.kind      = KIND_BYTE;
      end else begin
        out_data_nxt.data_byte = '0;
        out_data_nxt.kind      = head_job.tail_kind;
      end
      out_data_nxt.last = is_last;
      // advance within the job, or drop back to the first result
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/ascii85_decoder_unit.sv
// ASCII85 decoder top level: front end, job queue and back end.
// Uses a85_pkg, a85_front, a85_queue and a85_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one character per
//   transaction, or an end-of-stream marker (op = 1). Output channel
//   (out_valid/out_ready/out_data) carries one result per transaction:
//   a decoded byte, a done marker or an error code, with last set on the
//   final result of each input transaction that yields any.
//   With the back end idle, an accepted character's job is registered in
//   the queue and then in the output register before out_valid rises.
//   Throughput: one character per cycle while the queue is not full; the
//   output side gives one result per cycle while the receiver takes them,
//   so a group that yields four bytes occupies the back end while the
//   two-entry queue absorbs the following characters. The front end
//   handles each character with a single multiply-add by 85.
//   Reset (rst_n low, synchronous) clears the group, the error flag, the
//   queue and the output valid flag.
//   When the receiver stalls, the result holds in the output register,
//   the queue fills, and in_ready drops once it holds two jobs.
module ascii85_decoder_unit
  import a85_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic q_head_valid;
  job_t q_head_job;

  a85_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  a85_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  a85_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### src/a85_checker.sv
// Port-level checks for ascii85_decoder_unit, attached with bind.
// Uses out_item_t and kind codes from a85_pkg.
module a85_checker
  import a85_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // every non-byte result closes its transaction
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_BYTE |-> out_data.last)
    else $error("status result without last");

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_BYTE |-> out_data.data_byte == 8'd0)
    else $error("status result with nonzero byte");

endmodule

bind ascii85_decoder_unit a85_checker u_a85_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/a85_result_checker.sv
// Result checker for the ASCII85 decoder: watches both channels, decodes each
// accepted character or end marker itself and compares every result in order.
// Depends on a85_pkg for the payload types, kinds and character constants.
module a85_result_checker
  import a85_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        results_owed
);

  logic [31:0] acc;
  logic [2:0]  digits;
  logic        failed;
  out_item_t   decoded_q [$];
  out_item_t   want;

  function automatic out_item_t make_result(input logic [7:0] value, input kind_t kind);
    out_item_t r;
    r.data_byte = value;
    r.kind      = kind;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic void decode_item(input in_item_t item);
    out_item_t   res [4];
    int          n;
    int          i;
    logic [31:0] v;
    logic [2:0]  cnt;
    logic [7:0]  c;
    n = 0;
    c = item.char_code;
    if (item.op == OP_END) begin
      if (!failed) begin
        if (digits == 3'd1) begin
          res[n] = make_result(8'h00, KIND_INCOMPLETE);
          n++;
        end else begin
          // pad the partial group with 'u', keep one byte fewer than digits held
          v = acc;
          cnt = digits;
          while (cnt < GROUP_DIGITS) begin
            v = v * RADIX + 32'(CH_DIGIT_HIGH - CH_DIGIT_LOW);
            cnt++;
          end
          for (i = 0; i < int'(digits) - 1; i++) begin
            res[n] = make_result(8'(v >> (24 - 8 * i)), KIND_BYTE);
            n++;
          end
          res[n] = make_result(8'h00, KIND_DONE);
          n++;
        end
      end
      acc = '0;
      digits = '0;
      failed = 1'b0;
    end else if (!failed) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
        n = 0;
      end else if (c == CH_ZERO_GROUP) begin
        if (digits != 3'd0) begin
          failed = 1'b1;
          res[n] = make_result(8'h00, KIND_Z_IN_GROUP);
          n++;
        end else begin
          for (i = 0; i < 4; i++) begin
            res[n] = make_result(8'h00, KIND_BYTE);
            n++;
          end
        end
      end else if (c < CH_DIGIT_LOW || c > CH_DIGIT_HIGH) begin
        failed = 1'b1;
        res[n] = make_result(8'h00, KIND_BAD_CHAR);
        n++;
      end else begin
        acc = acc * RADIX + 32'(c - CH_DIGIT_LOW);
        digits++;
        if (digits == GROUP_DIGITS) begin
          for (i = 0; i < 4; i++) begin
            res[n] = make_result(8'(acc >> (24 - 8 * i)), KIND_BYTE);
            n++;
          end
          acc = '0;
          digits = '0;
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), res[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      acc = '0;
      digits = '0;
      failed = 1'b0;
      mismatch_count = 0;
      decoded_q.delete();
    end else begin
      // compare first: a result never comes out in the cycle of its own transaction
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: data_byte %0d kind %0d last %0d",
                 out_data.data_byte, out_data.kind, out_data.last);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0d, actual %0d", want.data_byte, out_data.data_byte);
            mismatch_count++;
          end
          if (out_data.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_data.kind);
            mismatch_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data.last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) decode_item(in_data);
    end
    results_owed = decoded_q.size();
  end

endmodule

### tb/ascii85_decoder_unit_tb.sv
// Testbench top for ascii85_decoder_unit: directed and random character streams,
// random idling on both channels, verdict from a85_result_checker.
// Depends on a85_pkg, ascii85_decoder_unit and a85_result_checker.
module ascii85_decoder_unit_tb;
  import a85_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int   mismatch_count;
  int   results_owed;
  int   items_sent;
  int   stalled_cycles;
  logic steady;
  logic hold_req;
  logic hold_taken;

  ascii85_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a85_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input in_item_t item);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t item;
    item.op = OP_CHAR;
    item.char_code = c;
    if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) items_sent++;
    send_item(item);
  endtask

  task automatic send_end();
    in_item_t item;
    item.op = OP_END;
    item.char_code = 8'($urandom_range(255));
    items_sent++;
    send_item(item);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid and wait until every decoded result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  task automatic well_formed_run(input int groups);
    int g;
    int d;
    int tail;
    for (g = 0; g < groups; g++) begin
      if ($urandom_range(9) == 0) begin
        send_char(CH_ZERO_GROUP);
      end else begin
        for (d = 0; d < 5; d++) begin
          if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
              0: send_char(CH_SPACE);
              1: send_char(CH_TAB);
              2: send_char(CH_LF);
              default: send_char(CH_CR);
            endcase
          end
          send_char(8'($urandom_range(CH_DIGIT_HIGH, CH_DIGIT_LOW)));
        end
      end
    end
    tail = $urandom_range(4);
    for (d = 0; d < tail; d++) send_char(8'($urandom_range(CH_DIGIT_HIGH, CH_DIGIT_LOW)));
    // break the stream now and then: stray 'z' or a byte past 'u', then a few dropped digits
    if ($urandom_range(5) == 0) begin
      if ($urandom_range(1) == 0) send_char(CH_ZERO_GROUP);
      else send_char(8'($urandom_range(8'hFF, 8'h76)));
      for (d = $urandom_range(2); d > 0; d--) begin
        send_char(8'($urandom_range(CH_DIGIT_HIGH, CH_DIGIT_LOW)));
      end
    end
    send_end();
  endtask

  task automatic noise_run();
    int k;
    for (k = $urandom_range(6, 1); k > 0; k--) send_char(8'($urandom_range(255)));
    send_end();
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("ascii85_decoder_unit_tb: FAIL");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero group, all-ones group with every blank inside, wrapping group
    send_text("z");
    send_text("s \t8\nW\r-!");
    send_text("uuuuu");
    // two digits pending at the end, empty end, lone trailing digit
    send_text("uu");
    send_end();
    send_end();
    send_text("!");
    send_end();
    // misplaced zero group, dropped character, end clears the error
    send_text("!z~");
    send_end();
    send_char(8'hFF);
    send_end();
    drain();

    // long hold-off on the result side while characters keep coming
    items_sent = 0;
    hold_req = 1'b1;
    well_formed_run(4);
    while (items_sent < RANDOM_ITEMS) begin
      steady = (items_sent >= 40 && items_sent < 70);
      if ($urandom_range(3) != 0) well_formed_run($urandom_range(4, 1));
      else noise_run();
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("ascii85_decoder_unit_tb: PASS");
    end else begin
      $display("ascii85_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
